FILE: rtl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg: shared types and constants for the vertex normal block
// Widths, the controller/datapath command and status bundles and config index codes.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxRows   = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxRows + 1);
  localparam int DimW      = 11;
  localparam int HeightW   = 16;
  localparam int DiffW     = 17;
  localparam int FaceW     = 2 * DiffW;
  localparam int SumW      = 20;
  localparam int LenW      = 42;
  localparam int NormW     = 16;
  localparam int QW        = 15;
  localparam int QMax      = 16384;

  localparam logic [0:0] CfgWidth  = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dz;
  } face_t;

  // controller -> datapath
  typedef struct packed {
    logic             rd;        // issue line reads for item
    logic             calc;      // read data ready, form faces and sum
    logic             norm_start;
    logic             drain;
    logic             emit;      // produce a result
    logic             has_right;
    logic             has_left;
    logic             has_prev;
    logic             done;
    logic [AddrW-1:0] col;
    logic             clear;     // restart: clear face registers
  } hvn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic norm_busy;
    logic out_full;
  } hvn_sts_t;

endpackage

FILE: rtl/heightmap_vertex_normals.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normals: averaged vertex normals of a height grid
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per transfer: tuser = kind (0 height sample,
//   1 drain item), tdata = signed Q8.8 height. heights come in raster order;
//   samples of row j >= 1 each give the normal of vertex (col, j-1), row 0
//   only fills the line buffer. after the last row, grid_width drain
//   transfers give the last row. items of the wrong kind are dropped.
//   m_axis carries {normal_z, normal_y, normal_x} Q1.14 in tdata and tlast
//   flags the final vertex of the grid.
//   sequence: an item without a result passes accept, read and calc; an item
//   with a result also runs the bit-serial normalizer (square and length
//   setup, then multiply, second multiply and compare per bit, 15 bits for
//   each of the three components). a new item is accepted only once the
//   current one is through.
//   the output register holds a result while the receiver stalls; the
//   next item passes the line buffers meanwhile and waits before its
//   normalization until the register is free.
//   reset: width and height are 1024, the grid position is cleared; a
//   configuration write also restarts the grid. no clearing pass is needed.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals
  import hvn_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [10:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,   // [15:0] height
  input  logic          s_axis_tuser,   // [0] kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,   // [15:0] x, [31:16] y, [47:32] z
  output logic          m_axis_tlast    // grid_done
);
  hvn_cmd_t cmd;
  hvn_sts_t sts;

  hvn_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx_i), .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_kind_i(s_axis_tuser),
    .in_ready_o(s_axis_tready), .sts_i(sts), .cmd_o(cmd));

  hvn_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .height_i(s_axis_tdata), .sts_o(sts),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast));
endmodule

FILE: rtl/hvn_ram.sv
// ----------------------------------------------------------------------------
// hvn_ram: generic single-port-write, one-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/hvn_norm.sv
// ----------------------------------------------------------------------------
// hvn_norm: iterative vector normalizer
// Bit-serial search of each Q1.14 component, one bit per multiply/compare pass; the
// wide length product is split over two stages of narrow multipliers.
// ----------------------------------------------------------------------------
module hvn_norm
  import hvn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] sx_i,
  input  logic signed [SumW-1:0] sy_i,
  input  logic signed [SumW-1:0] sz_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output logic [NormW-1:0]       nx_o,
  output logic [NormW-1:0]       ny_o,
  output logic [NormW-1:0]       nz_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StMul2 = 3'd5;
  localparam int         LoW    = LenW / 2;

  logic [2:0]            st_q, st_d;
  logic [SumW-2:0]       mag_q [3];
  logic                  neg_q [3];
  logic [2*SumW-3:0]     sq_q [3];
  logic [LenW-1:0]       len_q;
  logic [1:0]            comp_q;
  logic [3:0]            bit_q;
  logic [QW-1:0]         q_q;
  logic [QW-1:0]         cand;
  logic [QW:0]           t;
  logic [2*QW+1:0]       t2_q;
  logic [2*QW+1+LoW:0]   plo_q;
  logic [2*QW+1+LenW-LoW:0] phi;
  logic [NormW-1:0]      res_q [3];
  logic [2*QW+1+LenW:0]  lhs;
  logic [2*SumW+28:0]    rhs;
  logic                  fits;

  // candidate with the current bit set; 16384 only as the top bit alone
  assign cand = q_q | (QW'(1) << bit_q);
  assign t    = {cand, 1'b0} - (QW+1)'(1);
  // upper partial product, the lower one is registered in the preceding StMul2 state
  assign phi  = t2_q * len_q[LenW-1:LoW];
  assign lhs  = {phi, {LoW{1'b0}}} + (2*QW+2+LenW)'(plo_q);
  assign rhs  = {sq_q[comp_q], 30'd0};
  assign fits = (cand <= QW'(QMax)) && ((2*QW+2+LenW)'(lhs) <= (2*QW+2+LenW)'(rhs));

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (start_i) st_d = StSq;
      StSq:   st_d = StLen;
      StLen:  st_d = StMul;
      StMul:  st_d = StMul2;
      StMul2: st_d = StCmp;
      StCmp:  if (bit_q == 4'd0 && comp_q == 2'd2) st_d = StIdle;
              else st_d = StMul;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      valid_o <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_o <= (st_q == StCmp) && (bit_q == 4'd0) && (comp_q == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (start_i) begin
        mag_q[0] <= (SumW-1)'(sx_i < 0 ? -sx_i : sx_i);
        mag_q[1] <= (SumW-1)'(sy_i < 0 ? -sy_i : sy_i);
        mag_q[2] <= (SumW-1)'(sz_i < 0 ? -sz_i : sz_i);
        neg_q[0] <= sx_i < 0;
        neg_q[1] <= sy_i < 0;
        neg_q[2] <= sz_i < 0;
      end
      StSq: begin
        for (int k = 0; k < 3; k++) sq_q[k] <= mag_q[k] * mag_q[k];
      end
      StLen: begin
        len_q  <= LenW'(sq_q[0]) + LenW'(sq_q[1]) + LenW'(sq_q[2]);
        comp_q <= 2'd0;
        bit_q  <= 4'(QW-1);
        q_q    <= '0;
      end
      StMul:  t2_q <= t * t;
      StMul2: plo_q <= t2_q * len_q[LoW-1:0];
      StCmp: begin
        if (bit_q == 4'd0) begin
          res_q[comp_q] <= neg_q[comp_q] ? -NormW'(fits ? cand : q_q)
                                         : NormW'(fits ? cand : q_q);
          q_q    <= '0;
          bit_q  <= 4'(QW-1);
          comp_q <= comp_q + 2'd1;
        end else begin
          if (fits) q_q <= cand;
          bit_q <= bit_q - 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = st_q != StIdle;
  assign nx_o = res_q[0];
  assign ny_o = res_q[1];
  assign nz_o = res_q[2];
endmodule

FILE: rtl/hvn_datapath.sv
// ----------------------------------------------------------------------------
// hvn_datapath: line buffers, face forming, face sum and output register
// Driven by the controller through hvn_cmd_t.
// ----------------------------------------------------------------------------
module hvn_datapath
  import hvn_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hvn_cmd_t                  cmd_i,
  input  logic signed [HeightW-1:0] height_i,
  output hvn_sts_t                  sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [3*NormW-1:0]        out_data_o,
  output logic                      out_last_o
);
  logic [HeightW-1:0]        h_l, h_r;
  logic [FaceW-1:0]          f_rd;
  logic [AddrW-1:0]          col_q;
  logic signed [HeightW-1:0] hv_q;
  logic                      drain_q, right_q, left_q, prev_q, done_q, done_n_q;
  face_t                     left_face_q, upper_left_q, cur, above;
  logic signed [SumW-1:0]    sx, sy, sz, sx_q, sy_q, sz_q;
  logic                      n_valid;
  logic [NormW-1:0]          nx, ny, nz;
  logic                      calc_emit;

  // reads address the latched column, so data is ready in the calc cycle
  hvn_ram #(.Width(HeightW), .Depth(MaxWidth)) u_hl (
    .clk_i, .we_i(cmd_i.calc && !drain_q), .waddr_i(col_q),
    .wdata_i(hv_q), .raddr_i(col_q), .rdata_o(h_l));
  // second height copy serves the right-hand neighbor read
  hvn_ram #(.Width(HeightW), .Depth(MaxWidth)) u_hr (
    .clk_i, .we_i(cmd_i.calc && !drain_q), .waddr_i(col_q),
    .wdata_i(hv_q), .raddr_i(col_q + AddrW'(1)), .rdata_o(h_r));
  hvn_ram #(.Width(FaceW), .Depth(MaxWidth)) u_fl (
    .clk_i, .we_i(cmd_i.calc && cmd_i.emit && !drain_q && right_q),
    .waddr_i(col_q), .wdata_i(cur), .raddr_i(col_q), .rdata_o(f_rd));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      col_q   <= cmd_i.col;
      hv_q    <= height_i;
      drain_q <= cmd_i.drain;
      right_q <= cmd_i.has_right;
      left_q  <= cmd_i.has_left;
      prev_q  <= cmd_i.has_prev;
      done_q  <= cmd_i.done;
    end
  end

  always_comb begin
    cur   = '0;
    above = '0;
    if (right_q) begin
      above = face_t'(f_rd);
      if (!drain_q) begin
        cur.dx = DiffW'($signed(h_l)) - DiffW'($signed(h_r));
        cur.dz = DiffW'($signed(h_l)) - DiffW'(hv_q);
      end
    end
    sx = '0; sy = '0; sz = '0;
    if (left_q && prev_q) begin
      sx = sx + SumW'(upper_left_q.dx); sy = sy + SumW'(256);
      sz = sz + SumW'(upper_left_q.dz);
    end
    if (right_q && prev_q) begin
      sx = sx + SumW'(above.dx); sy = sy + SumW'(256); sz = sz + SumW'(above.dz);
    end
    if (left_q && !drain_q) begin
      sx = sx + SumW'(left_face_q.dx); sy = sy + SumW'(256);
      sz = sz + SumW'(left_face_q.dz);
    end
    if (right_q && !drain_q) begin
      sx = sx + SumW'(cur.dx); sy = sy + SumW'(256); sz = sz + SumW'(cur.dz);
    end
  end

  assign calc_emit = cmd_i.calc && cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_face_q  <= '0;
      upper_left_q <= '0;
    end else if (cmd_i.clear) begin
      left_face_q  <= '0;
      upper_left_q <= '0;
    end else if (calc_emit) begin
      upper_left_q <= above;
      if (!drain_q) left_face_q <= cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_emit) begin
      sx_q     <= sx;
      sy_q     <= sy;
      sz_q     <= sz;
      done_n_q <= done_q;
    end
  end

  hvn_norm u_norm (
    .clk_i, .rst_ni, .start_i(cmd_i.norm_start), .sx_i(sx_q), .sy_i(sy_q),
    .sz_i(sz_q), .busy_o(sts_o.norm_busy), .valid_o(n_valid),
    .nx_o(nx), .ny_o(ny), .nz_o(nz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (n_valid) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (n_valid) begin
      out_data_o <= {nz, ny, nx};
      out_last_o <= done_n_q;
    end
  end

  assign sts_o.out_full = out_valid_o;
endmodule

FILE: rtl/hvn_ctrl.sv
// ----------------------------------------------------------------------------
// hvn_ctrl: grid sequencer
// Holds configuration and grid position, steps each item through read and
// face/sum; an item with a result waits for the output register, then normalizes.
// ----------------------------------------------------------------------------
module hvn_ctrl
  import hvn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [DimW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  input  hvn_sts_t         sts_i,
  output hvn_cmd_t         cmd_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;
  localparam logic [1:0] StNorm = 2'd3;

  logic [1:0]      st_q, st_d;
  logic [DimW-1:0] w_cfg_q, h_cfg_q;
  logic [DimW-1:0] w, h;
  logic [AddrW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            emit_q;
  logic            acc, take, is_drain_ph, last_col, right;
  logic            started_q, norm_go;

  assign w = (w_cfg_q < DimW'(2)) ? DimW'(2) :
             (w_cfg_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : w_cfg_q;
  assign h = (h_cfg_q < DimW'(2)) ? DimW'(2) :
             (h_cfg_q > DimW'(MaxRows)) ? DimW'(MaxRows) : h_cfg_q;

  assign is_drain_ph = DimW'(row_q) == h;
  assign in_ready_o  = st_q == StIdle;
  assign acc         = in_valid_i && in_ready_o;
  assign take        = acc && (in_kind_i == is_drain_ph);
  assign last_col    = DimW'(col_q) + DimW'(1) >= w;
  assign right       = !last_col;

  // normalizer starts only once the output register is free
  assign norm_go = (st_q == StNorm) && !started_q && !sts_i.out_full;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (take) st_d = StRead;
      StRead: st_d = StCalc;
      StCalc: st_d = emit_q ? StNorm : StIdle;
      StNorm: if (started_q && !sts_i.norm_busy) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      w_cfg_q <= DimW'(1024);
      h_cfg_q <= DimW'(1024);
      col_q   <= '0;
      row_q   <= '0;
      emit_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgWidth) w_cfg_q <= cfg_data_i;
        else h_cfg_q <= cfg_data_i;
        col_q <= '0;
        row_q <= '0;
      end else if (take) begin
        emit_q <= is_drain_ph || row_q != '0;
        if (last_col) begin
          col_q <= '0;
          row_q <= is_drain_ph ? '0 : row_q + RowW'(1);
        end else begin
          col_q <= col_q + AddrW'(1);
        end
      end
    end
  end

  // set once the normalizer has been started for the current item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) started_q <= 1'b0;
    else if (st_q != StNorm) started_q <= 1'b0;
    else if (norm_go) started_q <= 1'b1;
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.rd         = take;
    cmd_o.col        = col_q;
    cmd_o.drain      = is_drain_ph;
    cmd_o.has_right  = right;
    cmd_o.has_left   = col_q != '0;
    cmd_o.has_prev   = is_drain_ph || row_q >= RowW'(2);
    cmd_o.done       = is_drain_ph && last_col;
    cmd_o.calc       = st_q == StCalc;
    cmd_o.emit       = emit_q;
    cmd_o.norm_start = norm_go;
    cmd_o.clear      = cfg_we_i;
  end
endmodule

FILE: rtl/hvn_checker.sv
// ----------------------------------------------------------------------------
// hvn_checker: port-level checks of the vertex normal block
// Bound to the top level.
// ----------------------------------------------------------------------------
module hvn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_y_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("normal y negative");
  a_x_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:14] == 2'b00 || m_axis_tdata[15:14] == 2'b11
                       || m_axis_tdata[15:0] == 16'h4000))
    else $error("normal x out of range");
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("stalled last flag changed");
endmodule

bind heightmap_vertex_normals hvn_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast);
